@@ hw/rtl/rbcg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Rainbow breathing color generator package
// Shared constants, types and the table builder for the sine lookup.
// ----------------------------------------------------------------------------
package rbcg_pkg;

	localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [7:0]  PEAK_LEVEL_RST = 8'd63;
	localparam logic [16:0] FULL_Q16       = 17'h10000;

	localparam logic [17:0]        PHASE_STEP = 18'd133509;
	localparam logic [13:0]        HUE_RECIP  = 14'd11651;
	localparam logic [15:0]        HUE_TURN   = 16'd360;
	localparam logic signed [15:0] V_SWING    = 16'sd13107;
	localparam logic signed [17:0] V_BASE     = 18'sd52429;
	localparam logic [15:0]        V_MIN      = 16'd39322;
	localparam logic [15:0]        FRAC_MAX   = 16'd64443;

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [0:0] {
		REG_PEAK_LEVEL = 1'b0,
		REG_SATURATION = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		SEC_RED_YELLOW    = 3'd0,
		SEC_YELLOW_GREEN  = 3'd1,
		SEC_GREEN_CYAN    = 3'd2,
		SEC_CYAN_BLUE     = 3'd3,
		SEC_BLUE_MAGENTA  = 3'd4,
		SEC_MAGENTA_RED   = 3'd5
	} sector_t;

	typedef struct packed {
		logic [7:0]  peak_level;
		logic [16:0] saturation;
	} cfg_t;

	typedef struct packed {
		logic [15:0] value;
		logic [15:0] frac;
		sector_t     sector;
	} hsv_t;

	// Sine magnitude in Q15 for quarter-turn position j of 2**qbits steps.
	function automatic logic [14:0] sine_mag_q15(input int unsigned j,
		input int unsigned qbits);
		logic [63:0] frac;
		logic [63:0] theta;
		logic [63:0] t2;
		logic [63:0] h;
		logic [63:0] s;
		frac  = (64'(j) << 30) >> qbits;
		theta = (frac * HALF_PI_Q30) >> 30;
		t2    = (theta * theta) >> 30;
		h     = Q30_ONE;
		h     = Q30_ONE - ((t2 * h) >> 30) / 64'd110;
		h     = Q30_ONE - ((t2 * h) >> 30) / 64'd72;
		h     = Q30_ONE - ((t2 * h) >> 30) / 64'd42;
		h     = Q30_ONE - ((t2 * h) >> 30) / 64'd20;
		h     = Q30_ONE - ((t2 * h) >> 30) / 64'd6;
		s     = (theta * h) >> 30;
		s     = (s + 64'd16384) >> 15;
		if (s > 64'd32767) begin
			s = 64'd32767;
		end
		return s[14:0];
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/rbcg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Rainbow breathing color generator configuration registers
// APB-style register file holding brightness and saturation.
// ----------------------------------------------------------------------------
module rbcg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [rbcg_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [rbcg_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic      [rbcg_pkg::CFG_DATA_W-1:0]  prdata,
	output rbcg_pkg::cfg_t                        cfg
);
	import rbcg_pkg::*;

	logic [7:0]  peak_level_q;
	logic [16:0] saturation_q;
	logic        wr_en;
	reg_idx_t    reg_idx;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_level_q <= PEAK_LEVEL_RST;
			saturation_q <= FULL_Q16;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PEAK_LEVEL: peak_level_q <= pwdata[7:0];
				REG_SATURATION: saturation_q <= pwdata[16:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PEAK_LEVEL: prdata = CFG_DATA_W'(peak_level_q);
			REG_SATURATION: prdata = CFG_DATA_W'(saturation_q);
		endcase
	end

	assign cfg.peak_level = peak_level_q;
	assign cfg.saturation = saturation_q;

endmodule
`default_nettype wire

@@ hw/rtl/rbcg_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Rainbow breathing color generator front end
// Three stages: phase and hue quotient, sine lookup and hue, value and sector.
// ----------------------------------------------------------------------------
module rbcg_front #(
	parameter int unsigned SINE_TABLE_DEPTH = rbcg_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] frame_index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output rbcg_pkg::hsv_t   hsv
);
	import rbcg_pkg::*;

	localparam int unsigned IDX_W   = $clog2(SINE_TABLE_DEPTH);
	localparam int unsigned QB      = IDX_W - 2;
	localparam int unsigned QUARTER = 1 << QB;
	localparam int unsigned ADDR_W  = QB + 1;

	logic [14:0] sine_rom [QUARTER+1];
	logic [15:0] frac_tbl [60];

	for (genvar g = 0; g <= QUARTER; g++) begin : g_sine
		assign sine_rom[g] = sine_mag_q15(g, QB);
	end

	for (genvar g = 0; g < 60; g++) begin : g_frac
		assign frac_tbl[g] = 16'((g * 65536) / 60);
	end

	logic en1, en2, en3;
	logic valid_s1, valid_s2, valid_s3;

	assign en3      = !valid_s3 || out_ready;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= in_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Stage 1: breathing phase and the quotient of the frame by a full turn.
	logic [33:0]      phase_prod;
	logic [26:0]      hue_prod;
	logic [IDX_W-1:0] idx_s1;
	logic [7:0]       turns_s1;
	logic [15:0]      frame_s1;

	assign phase_prod = 34'(frame_index) * 34'(PHASE_STEP);
	assign hue_prod   = 27'(frame_index[15:3]) * 27'(HUE_RECIP);

	always_ff @(posedge clk) begin
		if (en1) begin
			idx_s1   <= phase_prod[23 -: IDX_W];
			turns_s1 <= hue_prod[26:19];
			frame_s1 <= frame_index;
		end
	end

	// Stage 2: quarter-wave sine lookup and the hue angle.
	logic [1:0]        quad;
	logic [QB-1:0]     quad_pos;
	logic [ADDR_W-1:0] rom_addr;
	logic [15:0]       hue_full;
	logic [14:0]       mag_s2;
	logic              neg_s2;
	logic [8:0]        hue_s2;

	assign quad     = idx_s1[IDX_W-1 -: 2];
	assign quad_pos = idx_s1[QB-1:0];
	assign rom_addr = quad[0] ? ADDR_W'(QUARTER) - {1'b0, quad_pos} : {1'b0, quad_pos};
	assign hue_full = frame_s1 - 16'(16'(turns_s1) * HUE_TURN);

	always_ff @(posedge clk) begin
		if (en2) begin
			mag_s2 <= sine_rom[rom_addr];
			neg_s2 <= quad[1];
			hue_s2 <= hue_full[8:0];
		end
	end

	// Stage 3: breathing value, hue sector and fraction within the sector.
	logic signed [15:0] sine_val;
	logic signed [30:0] swing_prod;
	logic signed [17:0] value_sum;
	sector_t            sector;
	logic [8:0]         sector_base;
	logic [5:0]         sector_pos;
	hsv_t               hsv_s3;

	assign sine_val   = neg_s2 ? -$signed({1'b0, mag_s2}) : $signed({1'b0, mag_s2});
	assign swing_prod = 31'(V_SWING) * 31'(sine_val);
	assign value_sum  = V_BASE + 18'(swing_prod >>> 15);

	always_comb begin
		priority if (hue_s2 >= 9'd300) begin
			sector      = SEC_MAGENTA_RED;
			sector_base = 9'd300;
		end else if (hue_s2 >= 9'd240) begin
			sector      = SEC_BLUE_MAGENTA;
			sector_base = 9'd240;
		end else if (hue_s2 >= 9'd180) begin
			sector      = SEC_CYAN_BLUE;
			sector_base = 9'd180;
		end else if (hue_s2 >= 9'd120) begin
			sector      = SEC_GREEN_CYAN;
			sector_base = 9'd120;
		end else if (hue_s2 >= 9'd60) begin
			sector      = SEC_YELLOW_GREEN;
			sector_base = 9'd60;
		end else begin
			sector      = SEC_RED_YELLOW;
			sector_base = 9'd0;
		end
	end

	assign sector_pos = 6'(hue_s2 - sector_base);

	always_ff @(posedge clk) begin
		if (en3) begin
			hsv_s3.value  <= value_sum[15:0];
			hsv_s3.frac   <= frac_tbl[sector_pos];
			hsv_s3.sector <= sector;
		end
	end

	assign out_valid = valid_s3;
	assign hsv       = hsv_s3;

`ifndef SYNTHESIS
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> hsv_s3.value >= V_MIN)
		else $error("breathing value below its floor");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> hsv_s3.frac <= FRAC_MAX)
		else $error("sector fraction out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !out_ready |=> valid_s3 && $stable(hsv_s3))
		else $error("stalled item changed in stage 3");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/rbcg_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Rainbow breathing color generator back end
// Three stages: p and saturation terms, q and t, channel select and scaling.
// ----------------------------------------------------------------------------
module rbcg_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire rbcg_pkg::cfg_t cfg,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire rbcg_pkg::hsv_t hsv,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [7:0]          red,
	output logic [7:0]          green,
	output logic [7:0]          blue
);
	import rbcg_pkg::*;

	logic en4, en5, en6;
	logic valid_s4, valid_s5, valid_s6;

	assign en6      = !valid_s6 || out_ready;
	assign en5      = !valid_s5 || en6;
	assign en4      = !valid_s4 || en5;
	assign in_ready = en4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en4) begin
				valid_s4 <= in_valid;
			end
			if (en5) begin
				valid_s5 <= valid_s4;
			end
			if (en6) begin
				valid_s6 <= valid_s5;
			end
		end
	end

	// Stage 4: clamp saturation, form p and the two saturation products.
	logic [16:0] sat;
	logic [32:0] fs_prod;
	logic [33:0] gs_prod;
	logic [32:0] p_prod;
	logic [15:0] fs_s4;
	logic [16:0] gs_s4;
	logic [15:0] p_s4;
	logic [15:0] value_s4;
	sector_t     sector_s4;

	assign sat     = (cfg.saturation > FULL_Q16) ? FULL_Q16 : cfg.saturation;
	assign fs_prod = 33'(hsv.frac) * 33'(sat);
	assign gs_prod = 34'(FULL_Q16 - 17'(hsv.frac)) * 34'(sat);
	assign p_prod  = 33'(hsv.value) * 33'(FULL_Q16 - sat);

	always_ff @(posedge clk) begin
		if (en4) begin
			fs_s4     <= fs_prod[31:16];
			gs_s4     <= gs_prod[32:16];
			p_s4      <= p_prod[31:16];
			value_s4  <= hsv.value;
			sector_s4 <= hsv.sector;
		end
	end

	// Stage 5: the falling and rising terms q and t.
	logic [32:0] q_prod;
	logic [32:0] t_prod;
	logic [15:0] q_s5;
	logic [15:0] t_s5;
	logic [15:0] p_s5;
	logic [15:0] value_s5;
	sector_t     sector_s5;

	assign q_prod = 33'(value_s4) * 33'(FULL_Q16 - 17'(fs_s4));
	assign t_prod = 33'(value_s4) * 33'(FULL_Q16 - gs_s4);

	always_ff @(posedge clk) begin
		if (en5) begin
			q_s5      <= q_prod[31:16];
			t_s5      <= t_prod[31:16];
			p_s5      <= p_s4;
			value_s5  <= value_s4;
			sector_s5 <= sector_s4;
		end
	end

	// Stage 6: pick the channel fractions and scale them to the brightness.
	logic [15:0] r_frac, g_frac, b_frac;
	logic [23:0] r_prod, g_prod, b_prod;
	logic [7:0]  red_s6, green_s6, blue_s6;

	always_comb begin
		unique case (sector_s5)
			SEC_RED_YELLOW: begin
				r_frac = value_s5; g_frac = t_s5;     b_frac = p_s5;
			end
			SEC_YELLOW_GREEN: begin
				r_frac = q_s5;     g_frac = value_s5; b_frac = p_s5;
			end
			SEC_GREEN_CYAN: begin
				r_frac = p_s5;     g_frac = value_s5; b_frac = t_s5;
			end
			SEC_CYAN_BLUE: begin
				r_frac = p_s5;     g_frac = q_s5;     b_frac = value_s5;
			end
			SEC_BLUE_MAGENTA: begin
				r_frac = t_s5;     g_frac = p_s5;     b_frac = value_s5;
			end
			default: begin
				r_frac = value_s5; g_frac = p_s5;     b_frac = q_s5;
			end
		endcase
	end

	assign r_prod = 24'(r_frac) * 24'(cfg.peak_level);
	assign g_prod = 24'(g_frac) * 24'(cfg.peak_level);
	assign b_prod = 24'(b_frac) * 24'(cfg.peak_level);

	always_ff @(posedge clk) begin
		if (en6) begin
			red_s6   <= r_prod[23:16];
			green_s6 <= g_prod[23:16];
			blue_s6  <= b_prod[23:16];
		end
	end

	assign out_valid = valid_s6;
	assign red       = red_s6;
	assign green     = green_s6;
	assign blue      = blue_s6;

`ifndef SYNTHESIS
	a_terms_below_value: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> q_s5 <= value_s5 && t_s5 <= value_s5 && p_s5 <= value_s5)
		else $error("HSV term exceeds the value");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/rainbow_breathing_color_generator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Rainbow breathing color generator
// Turns a frame number into one HSV test-pattern color with breathing value.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// input     in_valid / in_ready    frame_index
// output    out_valid / out_ready  red, green, blue
// config    psel / penable         paddr, pwdata, pwrite, prdata
//
// Six register stages, three in rbcg_front and three in rbcg_back, lie between
// the input and the output; a result is presented from the last of them.
// One item per cycle is sustained while out_ready stays high; every stage is a pipeline register.
// Each full stage holds only while the next one holds, so empty stages keep filling
// and the input is taken while a finished result waits at the output.
// Reset clears the stage valid bits and returns the registers to defaults.
// ----------------------------------------------------------------------------
module rainbow_breathing_color_generator #(
	parameter int unsigned SINE_TABLE_DEPTH = rbcg_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [15:0]                     frame_index,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [7:0]                           red,
	output logic [7:0]                           green,
	output logic [7:0]                           blue,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [rbcg_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [rbcg_pkg::CFG_DATA_W-1:0] pwdata,
	output logic      [rbcg_pkg::CFG_DATA_W-1:0] prdata,
	output logic                                 pready
);
	import rbcg_pkg::*;

	cfg_t cfg;
	hsv_t hsv;
	logic hsv_valid;
	logic hsv_ready;

	assign pready = 1'b1;

	rbcg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	rbcg_front #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.frame_index (frame_index),
		.out_valid   (hsv_valid),
		.out_ready   (hsv_ready),
		.hsv         (hsv)
	);

	rbcg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (hsv_valid),
		.in_ready  (hsv_ready),
		.hsv       (hsv),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

endmodule
`default_nettype wire
